[sv/pidu_pkg.sv]
// Package: op codes, vectors, and the result beat type for the interrupt dispatch unit.
`default_nettype none
package pidu_pkg;

    typedef enum logic [2:0] {
        OP_CHECK  = 3'd0,
        OP_RAISE  = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_MASTER = 3'd3,
        OP_ENABLE = 3'd4,
        OP_HALT   = 3'd5
    } t_op;

    localparam logic [7:0] WAKE_MASK       = 8'h1F;
    localparam logic [7:0] BIT_VBLANK      = 8'h01;
    localparam logic [7:0] BIT_LCD         = 8'h02;
    localparam logic [7:0] BIT_TIMER       = 8'h04;
    localparam logic [7:0] BIT_JOYPAD      = 8'h10;
    localparam logic [7:0] VEC_VBLANK      = 8'h40;
    localparam logic [7:0] VEC_LCD         = 8'h48;
    localparam logic [7:0] VEC_TIMER       = 8'h50;
    localparam logic [7:0] VEC_JOYPAD      = 8'h60;
    localparam logic [4:0] DISPATCH_CYCLES = 5'd20;
    localparam logic [15:0] PUSH_BYTES     = 16'd2;

    typedef struct packed {
        logic        taken;
        logic [7:0]  jump_address;
        logic [15:0] pushed_pc;
        logic [15:0] new_sp;
        logic [4:0]  extra_cycles;
        logic        master_enabled;
        logic [7:0]  request_bits;
        logic [7:0]  enable_bits;
        logic        halted_now;
    } t_result;

endpackage
`default_nettype wire

[sv/pidu_if.sv]
// Interfaces: input and result channels of the interrupt dispatch unit.
`default_nettype none
interface pidu_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [7:0]  data;
    logic [15:0] current_pc;
    logic [15:0] current_sp;

    modport source (output valid, op, data, current_pc, current_sp, input ready);
    modport sink (input valid, op, data, current_pc, current_sp, output ready);
endinterface

interface pidu_out_if;
    logic        valid;
    logic        ready;
    logic        taken;
    logic [7:0]  jump_address;
    logic [15:0] pushed_pc;
    logic [15:0] new_sp;
    logic [4:0]  extra_cycles;
    logic        master_enabled;
    logic [7:0]  request_bits;
    logic [7:0]  enable_bits;
    logic        halted_now;

    modport source (
        output valid, taken, jump_address, pushed_pc, new_sp, extra_cycles,
               master_enabled, request_bits, enable_bits, halted_now,
        input  ready
    );
    modport sink (
        input  valid, taken, jump_address, pushed_pc, new_sp, extra_cycles,
               master_enabled, request_bits, enable_bits, halted_now,
        output ready
    );
endinterface
`default_nettype wire

[sv/pidu_ctrl.sv]
// Controller state registers and the fixed-priority dispatch decision for one beat.
`default_nettype none
module pidu_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [2:0]        i_op,
    input  wire logic [7:0]        i_data,
    input  wire logic [15:0]       i_pc,
    input  wire logic [15:0]       i_sp,
    output pidu_pkg::t_result      o_res
);

    logic [7:0] r_request, n_request;
    logic [7:0] r_enable, n_enable;
    logic       r_master, n_master;
    logic       r_halted, n_halted;

    logic [7:0] pend;
    logic       hit;
    logic [7:0] hit_bit;
    logic [7:0] hit_vec;

    always_comb begin
        pend = r_request & r_enable;
        hit  = 1'b1;
        if (pend[0]) begin
            hit_bit = pidu_pkg::BIT_VBLANK;
            hit_vec = pidu_pkg::VEC_VBLANK;
        end else if (pend[1]) begin
            hit_bit = pidu_pkg::BIT_LCD;
            hit_vec = pidu_pkg::VEC_LCD;
        end else if (pend[2]) begin
            hit_bit = pidu_pkg::BIT_TIMER;
            hit_vec = pidu_pkg::VEC_TIMER;
        end else if (pend[4]) begin
            hit_bit = pidu_pkg::BIT_JOYPAD;
            hit_vec = pidu_pkg::VEC_JOYPAD;
        end else begin
            hit     = 1'b0;
            hit_bit = 8'h00;
            hit_vec = 8'h00;
        end
    end

    always_comb begin
        n_request          = r_request;
        n_enable           = r_enable;
        n_master           = r_master;
        n_halted           = r_halted;
        o_res.taken        = 1'b0;
        o_res.jump_address = 8'h00;
        o_res.pushed_pc    = 16'h0000;
        o_res.new_sp       = i_sp;
        o_res.extra_cycles = 5'd0;
        case (pidu_pkg::t_op'(i_op))
            pidu_pkg::OP_RAISE:  n_request = r_request | i_data;
            pidu_pkg::OP_CLEAR:  n_request = r_request & ~i_data;
            pidu_pkg::OP_MASTER: n_master  = i_data[0];
            pidu_pkg::OP_ENABLE: n_enable  = i_data;
            pidu_pkg::OP_HALT:   n_halted  = 1'b1;
            pidu_pkg::OP_CHECK: begin
                if ((r_request & pidu_pkg::WAKE_MASK) != 8'h00) begin
                    n_halted = 1'b0;
                end
                if (r_master && hit) begin
                    o_res.taken        = 1'b1;
                    o_res.jump_address = hit_vec;
                    o_res.pushed_pc    = i_pc;
                    o_res.new_sp       = i_sp - pidu_pkg::PUSH_BYTES;
                    o_res.extra_cycles = pidu_pkg::DISPATCH_CYCLES;
                    n_master           = 1'b0;
                    n_request          = r_request & ~hit_bit;
                    n_halted           = 1'b0;
                end
            end
            default: begin
            end
        endcase
        o_res.master_enabled = n_master;
        o_res.request_bits   = n_request;
        o_res.enable_bits    = n_enable;
        o_res.halted_now     = n_halted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_request <= 8'h00;
            r_enable  <= 8'h00;
            r_master  <= 1'b0;
            r_halted  <= 1'b0;
        end else if (i_step) begin
            r_request <= n_request;
            r_enable  <= n_enable;
            r_master  <= n_master;
            r_halted  <= n_halted;
        end
    end

endmodule
`default_nettype wire

[sv/priority_interrupt_dispatch_unit.sv]
// Top level: input register, dispatch controller, and result register.
// An accepted beat passes the input register, then the result register, to o_out.
// Throughput: one beat per cycle; the input register advances whenever the
//   result register is empty or being drained, so both sides stream back to back.
// Reset: synchronous, active low; clears request, enable, master enable, halt,
//   and both valid flags.
`default_nettype none
module priority_interrupt_dispatch_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pidu_in_if.sink    i_in,
    pidu_out_if.source o_out
);

    logic        r_s1_valid;
    logic [2:0]  r_s1_op;
    logic [7:0]  r_s1_data;
    logic [15:0] r_s1_pc;
    logic [15:0] r_s1_sp;

    logic               r_out_valid;
    pidu_pkg::t_result  r_out;
    pidu_pkg::t_result  res;

    logic advance;
    logic step;

    assign advance    = !r_out_valid || o_out.ready;
    assign step       = r_s1_valid && advance;
    assign i_in.ready = !r_s1_valid || advance;

    pidu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_op    (r_s1_op),
        .i_data  (r_s1_data),
        .i_pc    (r_s1_pc),
        .i_sp    (r_s1_sp),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_op   <= i_in.op;
            r_s1_data <= i_in.data;
            r_s1_pc   <= i_in.current_pc;
            r_s1_sp   <= i_in.current_sp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.taken          = r_out.taken;
    assign o_out.jump_address   = r_out.jump_address;
    assign o_out.pushed_pc      = r_out.pushed_pc;
    assign o_out.new_sp         = r_out.new_sp;
    assign o_out.extra_cycles   = r_out.extra_cycles;
    assign o_out.master_enabled = r_out.master_enabled;
    assign o_out.request_bits   = r_out.request_bits;
    assign o_out.enable_bits    = r_out.enable_bits;
    assign o_out.halted_now     = r_out.halted_now;

endmodule
`default_nettype wire

[sv/pidu_checker.sv]
// Checker on the top-level ports of the interrupt dispatch unit, with its bind.
`default_nettype none
module pidu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        i_ready,
    input wire logic        i_taken,
    input wire logic [7:0]  i_jump_address,
    input wire logic [15:0] i_pushed_pc,
    input wire logic [4:0]  i_extra_cycles,
    input wire logic        i_master_enabled,
    input wire logic        i_halted_now
);

    ast_taken_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_taken |-> i_extra_cycles == pidu_pkg::DISPATCH_CYCLES
            && !i_master_enabled && !i_halted_now)
        else $error("dispatch beat with wrong cycles, master enable, or halt");

    ast_taken_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_taken |-> i_jump_address == pidu_pkg::VEC_VBLANK
            || i_jump_address == pidu_pkg::VEC_LCD
            || i_jump_address == pidu_pkg::VEC_TIMER
            || i_jump_address == pidu_pkg::VEC_JOYPAD)
        else $error("dispatch beat with unknown vector");

    ast_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_taken |-> i_jump_address == 8'h00 && i_pushed_pc == 16'h0000
            && i_extra_cycles == 5'd0)
        else $error("non-dispatch beat carries dispatch fields");

    ast_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

    ast_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_taken) && $stable(i_jump_address))
        else $error("stalled result beat changed");

endmodule

bind priority_interrupt_dispatch_unit pidu_checker u_pidu_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_out.valid),
    .i_ready          (o_out.ready),
    .i_taken          (o_out.taken),
    .i_jump_address   (o_out.jump_address),
    .i_pushed_pc      (o_out.pushed_pc),
    .i_extra_cycles   (o_out.extra_cycles),
    .i_master_enabled (o_out.master_enabled),
    .i_halted_now     (o_out.halted_now)
);
`default_nettype wire
